FILE: rtl/fisr_pkg.sv
// Shared constants and helper functions for the reciprocal square root block.
// Used by the float multiplier, the float subtractor and the top level.
package fisr_pkg;

   localparam logic [31:0] MAGIC_GUESS = 32'h5f3759df;
   localparam logic [31:0] FP_HALF     = 32'h3f000000;
   localparam logic [31:0] FP_THREE_HALVES = 32'h3fc00000;
   localparam logic [31:0] CANON_NAN   = 32'h7fc00000;
   localparam logic [30:0] INF_MAG     = 31'h7f800000;
   localparam int unsigned STAGES_PER_OP = 3;
   localparam int unsigned GUESS_TAPS  = 4 * STAGES_PER_OP;
   localparam int unsigned LATENCY     = 5 * STAGES_PER_OP;

   function automatic logic [5:0] lzc48(input logic [47:0] v);
      logic [5:0] cnt;
      cnt = 6'd48;
      for (int i = 0; i < 48; i++) begin
         if (v[i]) begin
            cnt = 6'(47 - i);
         end
      end
      return cnt;
   endfunction

   function automatic logic [4:0] lzc28(input logic [27:0] v);
      logic [4:0] cnt;
      cnt = 5'd28;
      for (int i = 0; i < 28; i++) begin
         if (v[i]) begin
            cnt = 5'(27 - i);
         end
      end
      return cnt;
   endfunction

endpackage

FILE: rtl/fisr_fmul.sv
// Three-stage single-precision multiplier with round-to-nearest-even and subnormals.
// Depends on fisr_pkg for the leading-zero count and special constants.
module fisr_fmul
   import fisr_pkg::*;
(
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] a_bits,
   input  logic [31:0] b_bits,
   output logic [31:0] p_bits
);

   logic [7:0]  a_exp, b_exp, a_eff, b_eff;
   logic [23:0] a_man, b_man;
   logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

   logic [47:0] prod_ff;
   logic [8:0]  esum_ff;
   logic        sign1_ff, nan1_ff, inf1_ff, zero1_ff;

   logic [5:0]  lz;
   logic [10:0] e_in;
   logic [47:0] norm_ff;
   logic [10:0] e_ff;
   logic        sign2_ff, nan2_ff, inf2_ff, zero2_ff;

   logic [6:0]  d;
   logic [9:0]  base;
   logic [73:0] w, r;
   logic        lost, guard, sticky, rup;
   logic [23:0] mant;
   logic [32:0] mag;
   logic [31:0] p_in;
   logic [31:0] p_ff;

   always_comb begin
      a_exp  = a_bits[30:23];
      b_exp  = b_bits[30:23];
      a_man  = {a_exp != 8'd0, a_bits[22:0]};
      b_man  = {b_exp != 8'd0, b_bits[22:0]};
      a_eff  = (a_exp == 8'd0) ? 8'd1 : a_exp;
      b_eff  = (b_exp == 8'd0) ? 8'd1 : b_exp;
      a_nan  = (a_exp == 8'hff) && (a_bits[22:0] != 23'd0);
      b_nan  = (b_exp == 8'hff) && (b_bits[22:0] != 23'd0);
      a_inf  = (a_exp == 8'hff) && (a_bits[22:0] == 23'd0);
      b_inf  = (b_exp == 8'hff) && (b_bits[22:0] == 23'd0);
      a_zero = (a_exp == 8'd0) && (a_bits[22:0] == 23'd0);
      b_zero = (b_exp == 8'd0) && (b_bits[22:0] == 23'd0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= a_man * b_man;
         esum_ff  <= {1'b0, a_eff} + {1'b0, b_eff};
         sign1_ff <= a_bits[31] ^ b_bits[31];
         nan1_ff  <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
         inf1_ff  <= a_inf | b_inf;
         zero1_ff <= a_zero | b_zero;
      end
   end

   always_comb begin
      lz   = lzc48(prod_ff);
      e_in = {2'b00, esum_ff} - 11'd126 - {5'd0, lz};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         norm_ff  <= prod_ff << lz;
         e_ff     <= e_in;
         sign2_ff <= sign1_ff;
         nan2_ff  <= nan1_ff;
         inf2_ff  <= inf1_ff;
         zero2_ff <= zero1_ff;
      end
   end

   always_comb begin
      if ($signed(e_ff) < 11'sd1) begin
         d    = ((11'd1 - e_ff) > 11'd74) ? 7'd74 : 7'(11'd1 - e_ff);
         base = 10'd0;
      end else begin
         d    = 7'd0;
         base = 10'(e_ff - 11'd1);
      end
      w      = {norm_ff, 26'd0};
      r      = w >> d;
      lost   = |(w & ~({74{1'b1}} << d));
      mant   = r[73:50];
      guard  = r[49];
      sticky = (|r[48:0]) | lost;
      rup    = guard & (sticky | mant[0]);
      mag    = {base, 23'd0} + {9'd0, mant} + {32'd0, rup};
      if (nan2_ff) begin
         p_in = CANON_NAN;
      end else if (inf2_ff) begin
         p_in = {sign2_ff, INF_MAG};
      end else if (zero2_ff) begin
         p_in = {sign2_ff, 31'd0};
      end else if (mag >= {2'b00, INF_MAG}) begin
         p_in = {sign2_ff, INF_MAG};
      end else begin
         p_in = {sign2_ff, mag[30:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
      end
   end

   assign p_bits = p_ff;

endmodule

FILE: rtl/fisr_fsub.sv
// Three-stage single-precision subtractor (a - b) with round-to-nearest-even.
// Depends on fisr_pkg for the leading-zero count and special constants.
module fisr_fsub
   import fisr_pkg::*;
(
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] a_bits,
   input  logic [31:0] b_bits,
   output logic [31:0] d_bits
);

   logic [7:0]  a_exp, b_exp, a_eff, b_eff, big_e, diff;
   logic [23:0] a_man, b_man, big_m, small_m;
   logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sa, sb;
   logic        a_big, big_s, small_s;
   logic [4:0]  d;
   logic [26:0] small27, al;

   logic [26:0] big1_ff, al1_ff;
   logic [7:0]  e1_ff;
   logic        s1_ff, sub1_ff, nan1_ff, inf1_ff, infs1_ff;

   logic [27:0] sum;
   logic [27:0] sum2_ff;
   logic [4:0]  lz2_ff;
   logic [7:0]  e2_ff;
   logic        s2_ff, sub2_ff, nan2_ff, inf2_ff, infs2_ff;

   logic [7:0]  sh;
   logic [27:0] n;
   logic [8:0]  base;
   logic [23:0] mant;
   logic        rup;
   logic [31:0] mag;
   logic [31:0] d_in;
   logic [31:0] d_ff;

   always_comb begin
      a_exp  = a_bits[30:23];
      b_exp  = b_bits[30:23];
      a_man  = {a_exp != 8'd0, a_bits[22:0]};
      b_man  = {b_exp != 8'd0, b_bits[22:0]};
      a_eff  = (a_exp == 8'd0) ? 8'd1 : a_exp;
      b_eff  = (b_exp == 8'd0) ? 8'd1 : b_exp;
      a_nan  = (a_exp == 8'hff) && (a_bits[22:0] != 23'd0);
      b_nan  = (b_exp == 8'hff) && (b_bits[22:0] != 23'd0);
      a_inf  = (a_exp == 8'hff) && (a_bits[22:0] == 23'd0);
      b_inf  = (b_exp == 8'hff) && (b_bits[22:0] == 23'd0);
      a_zero = (a_exp == 8'd0) && (a_bits[22:0] == 23'd0);
      b_zero = (b_exp == 8'd0) && (b_bits[22:0] == 23'd0);
      sa     = a_bits[31];
      sb     = ~b_bits[31];
      a_big  = {a_eff, a_man} >= {b_eff, b_man};
      big_e   = a_big ? a_eff : b_eff;
      big_m   = a_big ? a_man : b_man;
      big_s   = a_big ? sa : sb;
      small_m = a_big ? b_man : a_man;
      small_s = a_big ? sb : sa;
      diff    = a_big ? (a_eff - b_eff) : (b_eff - a_eff);
      d       = (diff > 8'd27) ? 5'd27 : diff[4:0];
      small27 = {small_m, 3'd0};
      al      = (small27 >> d) | {26'd0, |(small27 & ~({27{1'b1}} << d))};
      // Equal zeros of like sign keep that sign through the big/small path.
      if (a_zero && b_zero && (sa == sb)) begin
         big_s = sa;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         big1_ff  <= {big_m, 3'd0};
         al1_ff   <= al;
         e1_ff    <= big_e;
         s1_ff    <= big_s;
         sub1_ff  <= big_s ^ small_s;
         nan1_ff  <= a_nan | b_nan | (a_inf & b_inf & (sa != sb));
         inf1_ff  <= a_inf | b_inf;
         infs1_ff <= a_inf ? sa : sb;
      end
   end

   always_comb begin
      sum = sub1_ff ? ({1'b0, big1_ff} - {1'b0, al1_ff})
                    : ({1'b0, big1_ff} + {1'b0, al1_ff});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum2_ff  <= sum;
         lz2_ff   <= lzc28(sum);
         e2_ff    <= e1_ff;
         s2_ff    <= s1_ff;
         sub2_ff  <= sub1_ff;
         nan2_ff  <= nan1_ff;
         inf2_ff  <= inf1_ff;
         infs2_ff <= infs1_ff;
      end
   end

   always_comb begin
      sh   = ({3'd0, lz2_ff} < e2_ff) ? {3'd0, lz2_ff} : e2_ff;
      n    = sum2_ff << sh;
      base = {1'b0, e2_ff} - {1'b0, sh};
      mant = n[27:4];
      rup  = n[3] & ((|n[2:0]) | mant[0]);
      mag  = {base, 23'd0} + {8'd0, mant} + {31'd0, rup};
      if (nan2_ff) begin
         d_in = CANON_NAN;
      end else if (inf2_ff) begin
         d_in = {infs2_ff, INF_MAG};
      end else if (sum2_ff == 28'd0) begin
         d_in = {s2_ff & ~sub2_ff, 31'd0};
      end else if (mag >= {1'b0, INF_MAG}) begin
         d_in = {s2_ff, INF_MAG};
      end else begin
         d_in = {s2_ff, mag[30:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in;
      end
   end

   assign d_bits = d_ff;

endmodule

FILE: rtl/fast_inverse_square_root.sv
// Approximate reciprocal square root of a single-precision float.
// Usage:
//   A beat on the req_ channel carries req_x_bits, the operand as raw
//   IEEE-754 single-precision bits. A beat on the rsp_ channel carries
//   rsp_y_bits, the approximation of 1/sqrt(x) as raw bits. Results leave
//   in the order the operands arrived, one result for every operand.
//   The first guess is the magic constant minus the operand shifted right
//   arithmetically by one; one Newton step then refines it with four
//   multiplications and one subtraction, each rounded to nearest even.
//   Every NaN result is returned as the canonical quiet NaN.
// Throughput and pipeline:
//   A beat is accepted every cycle while req_stall is low; an accepted
//   beat reaches rsp_valid through five float units of three register stages each.
// Reset and stall:
//   Synchronous active-high reset empties the pipeline. While rsp_valid is
//   high and rsp_stall is asserted the whole pipeline holds and req_stall
//   is raised; no beat is lost or repeated.
// Depends on fisr_pkg, fisr_fmul and fisr_fsub.
module fast_inverse_square_root
   import fisr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_x_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_y_bits
);

   logic                 adv;
   logic [31:0]          guess;
   logic [31:0]          y_dly_ff [GUESS_TAPS];
   logic [LATENCY-1:0]   vld_ff;
   logic [LATENCY-1:0]   vld_in;
   logic [31:0]          half_bits, hy_bits, t_bits, u_bits;

   assign adv       = ~vld_ff[LATENCY-1] | ~rsp_stall;
   assign req_stall = ~adv;
   assign guess     = MAGIC_GUESS - {req_x_bits[31], req_x_bits[31:1]};
   assign vld_in    = {vld_ff[LATENCY-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         y_dly_ff[0] <= guess;
         for (int i = 1; i < GUESS_TAPS; i++) begin
            y_dly_ff[i] <= y_dly_ff[i-1];
         end
      end
   end

   fisr_fmul u_mul_half (
      .clock  (clock),
      .en     (adv),
      .a_bits (req_x_bits),
      .b_bits (FP_HALF),
      .p_bits (half_bits)
   );

   fisr_fmul u_mul_hy (
      .clock  (clock),
      .en     (adv),
      .a_bits (half_bits),
      .b_bits (y_dly_ff[STAGES_PER_OP-1]),
      .p_bits (hy_bits)
   );

   fisr_fmul u_mul_t (
      .clock  (clock),
      .en     (adv),
      .a_bits (hy_bits),
      .b_bits (y_dly_ff[2*STAGES_PER_OP-1]),
      .p_bits (t_bits)
   );

   fisr_fsub u_sub (
      .clock  (clock),
      .en     (adv),
      .a_bits (FP_THREE_HALVES),
      .b_bits (t_bits),
      .d_bits (u_bits)
   );

   fisr_fmul u_mul_y (
      .clock  (clock),
      .en     (adv),
      .a_bits (y_dly_ff[GUESS_TAPS-1]),
      .b_bits (u_bits),
      .p_bits (rsp_y_bits)
   );

   assign rsp_valid = vld_ff[LATENCY-1];

endmodule

FILE: rtl/fisr_checker.sv
// Port-level checks for the reciprocal square root block, bound to its top level.
// Depends only on the top-level ports.
module fisr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [31:0] req_x_bits,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_y_bits
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat shown straight after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_y_bits))
      else $error("stalled result beat changed");

   a_stall_cause: assert property (@(posedge clock)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled result");

   a_canon_nan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_y_bits[30:23] == 8'hff) && (rsp_y_bits[22:0] != 23'd0)
      |-> rsp_y_bits == 32'h7fc00000)
      else $error("non-canonical NaN in result beat");

endmodule

bind fast_inverse_square_root fisr_checker u_fisr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .req_x_bits (req_x_bits),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_y_bits (rsp_y_bits)
);

FILE: tb/fisr_checker.sv
// Watches both channels of the reciprocal square root block, predicts every result
// from its operand with IEEE single-precision rounding and compares in order.
// Depends on nothing but the port widths of fast_inverse_square_root.
module fisr_scoreboard (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [31:0] req_x_bits,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_y_bits,
   output int          fail_count,
   output int          pending,
   output int          checked
);

   typedef struct packed {
      logic [31:0] x_bits;
      logic [31:0] y_bits;
   } rsqrt_pair_type;

   rsqrt_pair_type rsqrt_expected[$];

   function automatic real single_to_real(input logic [31:0] b);
      logic [63:0] d;
      logic [22:0] m;
      int          p;
      m = b[22:0];
      d = '0;
      d[63] = b[31];
      if (b[30:23] == 8'hff) begin
         d[62:52] = 11'h7ff;
         d[51:29] = m;
      end else if (b[30:23] != 8'h00) begin
         d[62:52] = 11'(int'(b[30:23]) - 127 + 1023);
         d[51:29] = m;
      end else if (m != 0) begin
         p = 0;
         for (int i = 0; i < 23; i++) begin
            if (m[i]) begin
               p = i;
            end
         end
         d[62:52] = 11'(p - 149 + 1023);
         d[51:0] = 52'({29'b0, m} << (52 - p));
      end
      return $bitstoreal(d);
   endfunction

   // Rounds a double to single precision, nearest even, with gradual underflow.
   function automatic logic [31:0] real_to_single(input real r);
      logic [63:0] d;
      logic [63:0] sig;
      logic [63:0] kept;
      logic [63:0] rem;
      logic [63:0] halfway;
      logic [31:0] mag;
      int          e;
      int          shift;
      logic        up;
      d = $realtobits(r);
      if (d[62:52] == 11'h7ff) begin
         return {d[63], 8'hff, (d[51:0] != 0) ? 23'h400000 : 23'h0};
      end
      if (d[62:52] == 11'h000) begin
         return {d[63], 31'b0};
      end
      e = int'(d[62:52]) - 1023;
      if (e > 127) begin
         return {d[63], 8'hff, 23'h0};
      end
      sig = {11'b0, 1'b1, d[51:0]};
      shift = (e >= -126) ? 29 : 29 + (-126 - e);
      if (shift > 54) begin
         shift = 54;
      end
      kept = sig >> shift;
      rem = sig & ((64'd1 << shift) - 1);
      halfway = 64'd1 << (shift - 1);
      up = (rem > halfway) || (rem == halfway && kept[0]);
      if (e >= -126) begin
         mag = (32'(e + 127) << 23) + {9'b0, kept[22:0]} + 32'(up);
      end else begin
         mag = kept[31:0] + 32'(up);
      end
      return {d[63], mag[30:0]};
   endfunction

   function automatic logic [31:0] predict_rsqrt(input logic [31:0] x_bits);
      logic [31:0] guess;
      logic [31:0] yb;
      real         x;
      real         y;
      real         half;
      real         t;
      real         u;
      guess = 32'h5f3759df - {x_bits[31], x_bits[31:1]};
      x = single_to_real(x_bits);
      y = single_to_real(guess);
      half = single_to_real(real_to_single(x * 0.5));
      t = single_to_real(real_to_single(half * y));
      t = single_to_real(real_to_single(t * y));
      u = single_to_real(real_to_single(1.5 - t));
      yb = real_to_single(y * u);
      if (yb[30:23] == 8'hff && yb[22:0] != 0) begin
         yb = 32'h7fc00000;
      end
      return yb;
   endfunction

   assign pending = rsqrt_expected.size();

   always @(posedge clock) begin
      rsqrt_pair_type exp_pair;
      if (reset) begin
         rsqrt_expected.delete();
         fail_count <= 0;
         checked <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (rsqrt_expected.size() == 0) begin
               if (fail_count < 10) begin
                  $display("unexpected result beat %08h", rsp_y_bits);
               end
               fail_count <= fail_count + 1;
            end else begin
               exp_pair = rsqrt_expected.pop_front();
               checked <= checked + 1;
               if (exp_pair.y_bits !== rsp_y_bits) begin
                  if (fail_count < 10) begin
                     $display("mismatch x=%08h expected y=%08h actual y=%08h",
                              exp_pair.x_bits, exp_pair.y_bits, rsp_y_bits);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            exp_pair.x_bits = req_x_bits;
            exp_pair.y_bits = predict_rsqrt(req_x_bits);
            rsqrt_expected.push_back(exp_pair);
         end
      end
   end

   final begin
      if (rsqrt_expected.size() != 0) begin
         $display("%0d results never arrived", rsqrt_expected.size());
      end
   end

endmodule

FILE: tb/testbench.sv
// Top of the reciprocal square root testbench: clock, reset, operand stimulus,
// result back-pressure and the verdict. Depends on fisr_pkg, the block and fisr_scoreboard.
module testbench;
   import fisr_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 150;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_x_bits;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_y_bits;
   int          fail_count;
   int          pending;
   int          checked;
   int          phase;
   int          items_sent;
   int          cycles;
   int          hold_left;
   bit          hold_done;

   fast_inverse_square_root DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_x_bits(req_x_bits),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_y_bits(rsp_y_bits)
   );

   fisr_scoreboard u_scoreboard (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_x_bits(req_x_bits),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_y_bits(rsp_y_bits),
      .fail_count(fail_count), .pending(pending), .checked(checked)
   );

   initial begin
      clock = 0;
      reset = 1;
      req_valid = 0;
      req_x_bits = '0;
      rsp_stall = 0;
      phase = 0;
      items_sent = 0;
      cycles = 0;
      hold_left = 0;
      hold_done = 0;
   end

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("fast_inverse_square_root verification failed");
         $finish;
      end
   end

   // The receiver holds off once for a long stretch so that the pipeline fills.
   always @(posedge clock) begin
      int pct;
      pct = (phase == 0) ? 53 : (phase == 1) ? 28 : 0;
      if (reset) begin
         rsp_stall <= 0;
      end else if (!hold_done && items_sent >= 60) begin
         hold_done <= 1;
         hold_left <= 80;
         rsp_stall <= 1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < pct);
      end
   end

   function automatic logic [31:0] random_operand();
      int sel;
      sel = $urandom_range(99);
      if (sel < 50) begin
         return {1'b0, 8'($urandom_range(254, 1)), 23'($urandom)};
      end else if (sel < 70) begin
         return $urandom;
      end else if (sel < 85) begin
         return {1'($urandom), 8'h00, 23'($urandom)};
      end else begin
         return {1'($urandom), 8'hff, ($urandom_range(1) != 0) ? 23'h0 : 23'($urandom)};
      end
   endfunction

   task automatic send_operand(input logic [31:0] x);
      int pct;
      pct = (phase == 0) ? 28 : (phase == 1) ? 53 : 0;
      while ($urandom_range(99) < pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_x_bits <= x;
      do begin
         @(posedge clock);
      end while (req_stall);
      items_sent++;
   endtask

   logic [31:0] directed[] = '{
      32'h00000000, 32'h80000000, 32'h7f800000, 32'hff800000, 32'h7fc00000,
      32'h7f800001, 32'hffffffff, 32'h00000001, 32'h007fffff, 32'h00800000,
      32'h3f800000, 32'h40800000, 32'h7f7fffff, 32'h80000001, 32'hbf800000,
      32'h3e800000, 32'h5f3759df, 32'h00400000, 32'h7fffffff, 32'hbe9a0000
   };

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (directed[i]) begin
         send_operand(directed[i]);
      end
      for (int p = 0; p < 3; p++) begin
         phase = p;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_operand(random_operand());
         end
      end
      req_valid <= 0;
      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (LATENCY + 5) @(posedge clock);
      $display("%0d operands sent, %0d results checked: specials, subnormals and",
               items_sent, checked);
      $display("random floats under three stall mixes and one long result hold-off");
      if (fail_count == 0 && pending == 0) begin
         $display("fast_inverse_square_root verification clean");
      end else begin
         $display("fast_inverse_square_root verification failed");
      end
      $finish;
   end

endmodule
